FILE: rtl/core/btds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_pkg
// Shared types and constants for the binary to decimal string converter.
// ----------------------------------------------------------------------------
package btds_pkg;

    // field widths
    localparam int RAW_W      = 64;
    localparam int SIGN_W     = 8;
    localparam int SCALE_W    = 6;
    localparam int CHAR_W     = 6;
    localparam int LIMB_W     = 32;

    // conversion sizes
    localparam int BIN_W      = 2 * RAW_W;
    localparam int NUM_DIGITS = 40;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int POS_W      = $clog2(NUM_DIGITS + 1);

    // shift steps per mode: money is left aligned so only its 64 bits are walked
    localparam int MONEY_STEPS   = RAW_W;
    localparam int NUMERIC_STEPS = BIN_W;
    localparam int CNT_W         = $clog2(NUMERIC_STEPS + 1);

    // money always has four digits after the point
    localparam logic [SCALE_W-1:0] MONEY_SCALE = SCALE_W'(4);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // opcodes
    localparam logic OP_MONEY   = 1'b0;
    localparam logic OP_NUMERIC = 1'b1;

    // character codes, already reduced to six bits
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] CHAR_POINT = CHAR_W'(46);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

    // input transaction
    typedef struct packed {
        logic               opcode;
        logic [RAW_W-1:0]   raw_low;
        logic [RAW_W-1:0]   raw_high;
        logic [SIGN_W-1:0]  sign_byte;
        logic [SCALE_W-1:0] scale;
    } in_item_t;

    // output transaction
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic               money;
        logic               neg;
        logic [BIN_W-1:0]   mag;
        logic [SCALE_W-1:0] scale;
    } job_t;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

endpackage

FILE: rtl/core/binary_to_decimal_string_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_string_top
// Converts a money or numeric field to its decimal text, one character per
// output transaction.
// ----------------------------------------------------------------------------
// Each transaction turns into 1 to 42 characters: an optional '-', the
// digits with leading zeros dropped down to scale+1, and a '.' ahead of the
// last scale digits; last marks the final character. Work per transaction is
// set by the shift-and-add-3 unit in the back end: the job is loaded, its
// 64 money bits or 128 numeric bits are shifted in, leading zeros are then
// stripped one at a time (up to 35 for money, 39 for numeric), and the
// characters go out while out_ready is high. A
// two-entry queue sits between the classifying front end and the converter,
// so up to two further transactions are taken while one is converted or its
// characters are still going out.
// ----------------------------------------------------------------------------
module binary_to_decimal_string_top
    import btds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // decode and sign handling
    btds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue
    btds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // conversion and character output
    btds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/core/btds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_front
// Accepts input transactions, decodes the field layout and sign, and builds
// the magnitude that the back end converts, left-aligned for money.
// ----------------------------------------------------------------------------
module btds_front
    import btds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     push_valid,
    input  logic     push_ready,
    output job_t     push_job
);

    logic             money_neg;
    logic [RAW_W-1:0] money_mag;
    logic [BIN_W-1:0] numeric_mag;
    logic             busy_reg;
    logic             busy_next;

    // money: 64-bit two's complement, negate to a magnitude
    assign money_neg = in_item.raw_low[RAW_W-1];
    assign money_mag = money_neg ? (~in_item.raw_low + RAW_W'(1)) : in_item.raw_low;

    // numeric: four 32-bit little-endian words, most significant word first
    assign numeric_mag = {in_item.raw_low[LIMB_W-1:0],
                          in_item.raw_low[RAW_W-1:LIMB_W],
                          in_item.raw_high[LIMB_W-1:0],
                          in_item.raw_high[RAW_W-1:LIMB_W]};

    // classify the transaction into a job
    always_comb
    begin
        push_job = '0;
        if (in_item.opcode == OP_MONEY)
        begin
            push_job.money = 1'b1;
            push_job.neg   = money_neg;
            push_job.mag   = {money_mag, {(BIN_W - RAW_W){1'b0}}};
            push_job.scale = MONEY_SCALE;
        end
        else
        begin
            push_job.money = 1'b0;
            push_job.neg   = in_item.sign_byte[SIGN_W-1];
            push_job.mag   = numeric_mag;
            push_job.scale = in_item.scale;
        end
    end

    // hold off acceptance while reset is asserted or just released
    assign busy_next  = 1'b0;
    assign in_ready   = push_ready && !busy_reg;
    assign push_valid = in_valid && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: rtl/core/btds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_queue
// Short job queue that lets the front accept while the back converts.
// ----------------------------------------------------------------------------
module btds_queue
    import btds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_Q-1:0] count_reg;
    logic [CNT_Q-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_Q'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_Q'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/btds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_back
// Shift-and-add-3 conversion to 40 BCD digits, leading zero stripping, and
// character emission through a registered output stage.
// ----------------------------------------------------------------------------
module btds_back
    import btds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] scale_next;
    logic               neg_reg;
    logic               neg_next;
    logic               dot_reg;
    logic               dot_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         top_digit;
    logic               can_emit;
    logic               more_zeros;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign can_emit   = !out_valid_reg || out_ready;
    assign more_zeros = ({1'b0, pos_reg} > ({1'b0, scale_reg} + (SCALE_W + 1)'(1)))
                        && (top_digit == 4'd0);

    // sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        scale_next     = scale_reg;
        neg_next       = neg_reg;
        dot_next       = dot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        job_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_ready  = 1'b1;
                    bin_next   = job.mag;
                    bcd_next   = '0;
                    cnt_next   = job.money ? CNT_W'(MONEY_STEPS) : CNT_W'(NUMERIC_STEPS);
                    pos_next   = POS_W'(NUM_DIGITS);
                    scale_next = job.scale;
                    neg_next   = job.neg;
                    dot_next   = 1'b0;
                    state_next = ST_CONV;
                end
            end

            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_SKIP;
                end
            end

            // drop one leading zero per cycle, never below scale+1 digits
            ST_SKIP:
            begin
                if (more_zeros)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    pos_next = pos_reg - POS_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end

            ST_SIGN:
            begin
                if (can_emit)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.char_code = CHAR_MINUS;
                    out_item_next.last      = 1'b0;
                    state_next              = ST_EMIT;
                end
            end

            // point before the digit whose position equals the scale
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if ((pos_reg == POS_W'(scale_reg)) && !dot_reg)
                    begin
                        out_item_next.char_code = CHAR_POINT;
                        out_item_next.last      = 1'b0;
                        dot_next                = 1'b1;
                    end
                    else
                    begin
                        out_item_next.char_code = CHAR_ZERO + {2'b00, top_digit};
                        out_item_next.last      = (pos_reg == POS_W'(1));
                        bcd_next                = {bcd_reg[BCD_W-5:0], 4'd0};
                        pos_next                = pos_reg - POS_W'(1);
                        dot_next                = 1'b0;
                        if (pos_reg == POS_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        scale_reg    <= scale_next;
        neg_reg      <= neg_next;
        dot_reg      <= dot_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/core/btds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btds_checker
// Port level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
module btds_checker
    import btds_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input transaction changed while stalled");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output transaction changed while stalled");

    // only minus, point or a digit ever leaves
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.char_code == CHAR_MINUS)
                   || (out_item.char_code == CHAR_POINT)
                   || ((out_item.char_code >= CHAR_ZERO)
                       && (out_item.char_code <= CHAR_ZERO + CHAR_W'(9))))
        else $error("illegal character code");

    // the string always ends on a digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last |-> (out_item.char_code >= CHAR_ZERO))
        else $error("string ended on a sign or point");

    // a point is always followed by a digit, never by another point or sign
    a_point_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (out_item.char_code == CHAR_POINT)
        |=> !out_valid || (out_item.char_code >= CHAR_ZERO))
        else $error("point not followed by a digit");

endmodule

bind binary_to_decimal_string_top btds_checker u_btds_checker (.*);
